// File: src/sfd_pkg.sv
// Shared constants and the CRC-16/X.25 byte update for the stuffed frame decoder.
// No dependencies; used by the decoder top level and its bench.
package sfd_pkg;

	localparam int DEF_MAX_FRAME_LEN = 64;
	localparam int MAX_RESULTS       = 64;
	localparam int CNT_W             = 7;

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// register indexes on the config port
	localparam logic [1:0] REG_HEAD    = 2'd0;
	localparam logic [1:0] REG_ESCAPE  = 2'd1;
	localparam logic [1:0] REG_MIN_LEN = 2'd2;
	localparam logic [1:0] REG_MAX_LEN = 2'd3;

	localparam logic [7:0]       RST_HEAD    = 8'd170;
	localparam logic [7:0]       RST_ESCAPE  = 8'd85;
	localparam logic [CNT_W-1:0] RST_MIN_LEN = 7'd2;
	localparam logic [CNT_W-1:0] RST_MAX_LEN = 7'd64;

	// frame_status codes
	localparam logic [1:0] ST_PAYLOAD  = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_FORMAT   = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// reflected CRC, one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: src/sfd_store.sv
// Payload store: one write port, one read port with registered read data.
// Does not import sfd_pkg; depth set by parent.
module sfd_store #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/stuffed_frame_decoder_crc_bcc.sv
// Byte-stuffed frame decoder with CRC-16/X.25 or XOR check, top level.
// Depends on sfd_pkg and sfd_store.
//
// Usage:
//   Input stream s_*: one raw received byte per word in s_tdata[7:0].
//   Output stream m_*: one result per word; m_tdata holds the unstuffed
//   payload byte (zero for status results), m_tlast marks the final word
//   of a frame, m_tuser holds the frame status (0 payload, 1 check
//   mismatch, 2 format error, 3 valid empty frame). Config port, write only:
//   cfg_we/cfg_addr/cfg_wdata; user writes it only while idle, not enforced.
// Timing:
//   The byte that closes a frame is followed by a check state; a good
//   frame then walks the payload store, reading each payload byte and
//   then loading it into the output register, since the store has a
//   single registered read port. Input is held off (s_tready low)
//   during the check and the walk.
//   A format error result is loaded into the output register on the edge
//   that takes the offending byte; a mismatch or empty-frame result is
//   loaded on the edge that leaves the check state.
// Reset: hunting for the first head byte, output empty, registers at their
//   defaults. The store needs no clearing; it is written before it is read.
// Stall: while m_tready is low the output register holds its word; s_tready
//   stays low as long as that word waits, and the check and walk pause.
module stuffed_frame_decoder_crc_bcc
	import sfd_pkg::*;
#(
	parameter int MAX_FRAME_LEN = DEF_MAX_FRAME_LEN
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] payload_byte
	output logic       m_tlast,    // last_of_frame
	output logic [1:0] m_tuser,    // [1:0] frame_status
	input  logic       cfg_we,
	input  logic [1:0] cfg_addr,
	input  logic [7:0] cfg_wdata
);

	localparam int AW = $clog2(MAX_FRAME_LEN);

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_HEAD2   = 3'd1;
	localparam logic [2:0] PH_CTL     = 3'd2;
	localparam logic [2:0] PH_LEN     = 3'd3;
	localparam logic [2:0] PH_BODY    = 3'd4;
	localparam logic [2:0] PH_CHECK   = 3'd5;
	localparam logic [2:0] PH_EMIT_RD = 3'd6;
	localparam logic [2:0] PH_EMIT_WR = 3'd7;

	// config registers
	logic [7:0]       head_q, esc_byte_q;
	logic [CNT_W-1:0] min_q, max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= RST_HEAD;
			esc_byte_q <= RST_ESCAPE;
			min_q      <= RST_MIN_LEN;
			max_q      <= RST_MAX_LEN;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_HEAD:    head_q     <= cfg_wdata;
				REG_ESCAPE:  esc_byte_q <= cfg_wdata;
				REG_MIN_LEN: min_q      <= cfg_wdata[CNT_W-1:0];
				REG_MAX_LEN: max_q      <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// frame state
	logic [2:0]       phase_q;
	logic             esc_pend_q;
	logic [CNT_W-1:0] cnt_q;      // unstuffed count, reused as walk index
	logic             crc_mode_q; // 1: CRC check, 0: XOR check
	logic [CNT_W-1:0] len_q;
	logic [15:0]      crc_q;
	logic [7:0]       xor_q;
	logic [15:0]      hist_q;     // last two check bytes, high byte first

	// output register
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;
	logic [1:0] out_stat_q;

	logic out_free;
	logic in_phase;
	logic take;

	assign out_free = !out_valid_q || m_tready;
	assign in_phase = (phase_q != PH_CHECK) && (phase_q != PH_EMIT_RD) &&
		(phase_q != PH_EMIT_WR);
	assign s_tready = in_phase && out_free;
	assign take     = s_tvalid && s_tready;

	logic [7:0]       b;
	logic [CNT_W-1:0] chk;
	logic [CNT_W-1:0] pay;
	logic [CNT_W-1:0] idx_inc;
	logic [15:0]      crc_fed;
	logic             len_bad;
	logic             check_ok;

	assign b       = s_tdata[7:0];
	assign chk     = crc_mode_q ? CNT_W'(2) : CNT_W'(1);
	assign pay     = len_q - chk;
	assign idx_inc = cnt_q + CNT_W'(1);
	assign crc_fed = crc_byte(crc_q, b);

	// length byte check; chk here comes from the control byte already taken
	always_comb begin
		logic [7:0] chk8;
		chk8    = {1'b0, chk};
		len_bad = (b < {1'b0, min_q}) || (b > {1'b0, max_q}) ||
			({1'b0, b} > 9'(MAX_FRAME_LEN)) || (b < chk8) ||
			((b - chk8) > 8'(MAX_RESULTS));
	end

	assign check_ok = crc_mode_q ? ((~crc_q) == hist_q) : (xor_q == hist_q[7:0]);

	// store ports
	logic          st_we, st_re;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [7:0]    st_wdata, st_rdata;

	sfd_store #(
		.DEPTH(MAX_FRAME_LEN),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	// body byte decode
	logic       body_brk;   // broken escape
	logic       body_cmp;   // unstuffed byte complete
	logic [7:0] body_val;
	logic       in_pay;

	always_comb begin
		body_brk = 1'b0;
		body_cmp = 1'b1;
		body_val = b;
		if (esc_pend_q) begin
			body_brk = (b != esc_byte_q);
			body_val = head_q;
		end else if (b == head_q) begin
			body_cmp = 1'b0;
		end
	end

	assign in_pay   = cnt_q < pay;
	assign st_we    = take && (phase_q == PH_BODY) && !body_brk && body_cmp && in_pay &&
		({1'b0, cnt_q} < 8'(MAX_FRAME_LEN));
	assign st_waddr = AW'(cnt_q);
	assign st_wdata = body_val;
	assign st_re    = (phase_q == PH_EMIT_RD);
	assign st_raddr = AW'(cnt_q);

	// control
	logic       st_load;
	logic [7:0] st_ld_data;
	logic       st_ld_last;
	logic [1:0] st_ld_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			esc_pend_q <= 1'b0;
			cnt_q      <= '0;
			crc_mode_q <= 1'b0;
			len_q      <= '0;
			crc_q      <= CRC_INIT;
			xor_q      <= '0;
			hist_q     <= '0;
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (take && b == head_q) begin
						crc_q      <= crc_byte(CRC_INIT, b);
						xor_q      <= b;
						esc_pend_q <= 1'b0;
						cnt_q      <= '0;
						phase_q    <= PH_HEAD2;
					end
				end
				PH_HEAD2: begin
					if (take) begin
						if (b == head_q) begin
							crc_q   <= crc_fed;
							xor_q   <= xor_q ^ b;
							phase_q <= PH_CTL;
						end else begin
							phase_q <= PH_HUNT;
						end
					end
				end
				PH_CTL: begin
					if (take) begin
						crc_mode_q <= !b[6];
						crc_q      <= crc_fed;
						xor_q      <= xor_q ^ b;
						phase_q    <= PH_LEN;
					end
				end
				PH_LEN: begin
					if (take) begin
						crc_q <= crc_fed;
						xor_q <= xor_q ^ b;
						esc_pend_q <= 1'b0;
						if (len_bad) begin
							phase_q <= PH_HUNT;
						end else begin
							len_q   <= b[CNT_W-1:0];
							cnt_q   <= '0;
							hist_q  <= '0;
							phase_q <= PH_BODY;
						end
					end
				end
				PH_BODY: begin
					if (take) begin
						if (body_brk) begin
							esc_pend_q <= 1'b0;
							phase_q    <= PH_HUNT;
						end else begin
							esc_pend_q <= !esc_pend_q && (b == head_q);
							if (in_pay) begin
								crc_q <= crc_fed;
								xor_q <= xor_q ^ b;
							end
							if (body_cmp) begin
								if (!in_pay) begin
									hist_q <= {hist_q[7:0], body_val};
								end
								cnt_q <= idx_inc;
								if (idx_inc >= len_q) begin
									phase_q <= PH_CHECK;
								end
							end
						end
					end
				end
				PH_CHECK: begin
					if (out_free) begin
						cnt_q <= '0;
						if (check_ok && pay != '0) begin
							phase_q <= PH_EMIT_RD;
						end else begin
							esc_pend_q <= 1'b0;
							phase_q    <= PH_HUNT;
						end
					end
				end
				PH_EMIT_RD: begin
					phase_q <= PH_EMIT_WR;
				end
				PH_EMIT_WR: begin
					if (out_free) begin
						if (idx_inc == pay) begin
							esc_pend_q <= 1'b0;
							phase_q    <= PH_HUNT;
						end else begin
							cnt_q   <= idx_inc;
							phase_q <= PH_EMIT_RD;
						end
					end
				end
				default: phase_q <= PH_HUNT;
			endcase
		end
	end

	// what goes into the output register this cycle
	always_comb begin
		st_load    = 1'b0;
		st_ld_data = '0;
		st_ld_last = 1'b1;
		st_ld_stat = ST_FORMAT;
		if (take && phase_q == PH_LEN && len_bad) begin
			st_load = 1'b1;
		end else if (take && phase_q == PH_BODY && body_brk) begin
			st_load = 1'b1;
		end else if (phase_q == PH_CHECK && out_free) begin
			if (!check_ok) begin
				st_load    = 1'b1;
				st_ld_stat = ST_MISMATCH;
			end else if (pay == '0) begin
				st_load    = 1'b1;
				st_ld_stat = ST_EMPTY;
			end
		end else if (phase_q == PH_EMIT_WR && out_free) begin
			st_load    = 1'b1;
			st_ld_data = st_rdata;
			st_ld_last = (idx_inc == pay);
			st_ld_stat = ST_PAYLOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_load) begin
			out_data_q <= st_ld_data;
			out_last_q <= st_ld_last;
			out_stat_q <= st_ld_stat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_stat_q;

endmodule

// File: bench/stuffed_frame_decoder_crc_bcc_tb.sv
// Self-checking bench for the stuffed frame decoder: directed and random byte streams.
// Keeps its own decoder model and compares every output word with it.
// Depends on sfd_pkg and stuffed_frame_decoder_crc_bcc.
module stuffed_frame_decoder_crc_bcc_tb;
	import sfd_pkg::*;

	localparam int  SETTLE_CYCLES = 16;
	localparam int  END_CYCLES    = 2 * MAX_RESULTS + 16;
	localparam int  IDLE_PCT      = 11;
	localparam int  RANDOM_BYTES  = 10;     // per random settings phase, four phases
	localparam bit  MODE_CRC      = 1'b0;   // control byte bit 6 clear
	localparam bit  MODE_XOR      = 1'b1;   // control byte bit 6 set

	typedef enum logic [2:0] {
		PH_HUNT, PH_HEAD2, PH_CTRL, PH_LENGTH, PH_BODY
	} decode_phase_t;

	typedef enum int {
		FRAME_OK, FRAME_BAD_CHECK, FRAME_BAD_ESCAPE, FRAME_TRUNCATED
	} frame_fault_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] status;
	} result_word_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;    // [7:0] rx_byte
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;    // [7:0] payload_byte
	logic       m_tlast;    // last_of_frame
	logic [1:0] m_tuser;    // [1:0] frame_status
	logic       cfg_we;
	logic [1:0] cfg_addr;
	logic [7:0] cfg_wdata;

	stuffed_frame_decoder_crc_bcc dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// register copies, as the block holds them after masking
	logic [7:0] set_head;
	logic [7:0] set_escape;
	logic [6:0] set_min;
	logic [6:0] set_max;

	// decoder model state
	decode_phase_t dec_phase;
	logic          dec_esc_pending;
	logic [6:0]    dec_count;
	logic          dec_crc_mode;     // 1: two-byte CRC check
	logic [6:0]    dec_length;
	logic [7:0]    dec_store [DEF_MAX_FRAME_LEN];
	logic [15:0]   dec_crc;
	logic [7:0]    dec_bcc;
	logic [23:0]   dec_check_hist;

	result_word_t  expected_words[$];
	logic [7:0]    frame_payload[$];
	logic [7:0]    frame_raw[$];
	result_word_t  mon_got;
	result_word_t  mon_want;
	int            error_count;
	int            sent_bytes;
	bit            steady_mode;      // no idling on either side while set

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- model

	// CRC-16/X.25, one input bit at a time, LSB first
	function automatic logic [15:0] x25_crc_update(input logic [15:0] crc,
			input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void absorb_check(input logic [7:0] b);
		dec_crc = x25_crc_update(dec_crc, b);
		dec_bcc = dec_bcc ^ b;
	endfunction

	function automatic void push_status(input logic [1:0] st);
		result_word_t w;
		w.data   = 8'h00;
		w.last   = 1'b1;
		w.status = st;
		expected_words.push_back(w);
		dec_phase       = PH_HUNT;
		dec_esc_pending = 1'b0;
	endfunction

	function automatic void close_frame();
		int           chk;
		int           pay;
		logic         good;
		result_word_t w;
		chk = dec_crc_mode ? 2 : 1;
		pay = int'(dec_length) - chk;
		if (dec_crc_mode) begin
			good = (~dec_crc) == dec_check_hist[15:0];
		end else begin
			good = dec_bcc == dec_check_hist[7:0];
		end
		if (!good) begin
			push_status(ST_MISMATCH);
		end else if (pay == 0) begin
			push_status(ST_EMPTY);
		end else begin
			for (int i = 0; i < pay && i < DEF_MAX_FRAME_LEN && i < MAX_RESULTS; i++) begin
				w.data   = dec_store[i];
				w.last   = (i == pay - 1);
				w.status = ST_PAYLOAD;
				expected_words.push_back(w);
			end
			dec_phase       = PH_HUNT;
			dec_esc_pending = 1'b0;
		end
	endfunction

	// one accepted raw byte through the decoder model
	function automatic void decode_byte(input logic [7:0] b);
		int         chk;
		int         pay;
		int         idx;
		logic [7:0] value;
		logic       complete;
		chk = dec_crc_mode ? 2 : 1;
		case (dec_phase)
			PH_HEAD2: begin
				if (b == set_head) begin
					absorb_check(b);
					dec_phase = PH_CTRL;
				end else begin
					dec_phase = PH_HUNT;
				end
			end
			PH_CTRL: begin
				dec_crc_mode = ~b[6];
				absorb_check(b);
				dec_phase = PH_LENGTH;
			end
			PH_LENGTH: begin
				absorb_check(b);
				if (b < set_min || b > set_max || b > DEF_MAX_FRAME_LEN || b < chk ||
						int'(b) - chk > MAX_RESULTS) begin
					push_status(ST_FORMAT);
				end else begin
					dec_length      = b[6:0];
					dec_count       = '0;
					dec_esc_pending = 1'b0;
					dec_check_hist  = '0;
					dec_phase       = PH_BODY;
				end
			end
			PH_BODY: begin
				pay      = int'(dec_length) - chk;
				idx      = int'(dec_count);
				value    = b;
				complete = 1'b1;
				if (dec_esc_pending) begin
					if (b != set_escape) begin
						push_status(ST_FORMAT);
						return;
					end
					dec_esc_pending = 1'b0;
					value           = set_head;
				end else if (b == set_head) begin
					dec_esc_pending = 1'b1;
					complete        = 1'b0;
				end
				// raw bytes, escapes included, count toward the check
				if (idx < pay) begin
					absorb_check(b);
				end
				if (complete) begin
					if (idx < pay) begin
						if (idx < DEF_MAX_FRAME_LEN) begin
							dec_store[idx] = value;
						end
					end else begin
						dec_check_hist = {dec_check_hist[15:0], value};
					end
					dec_count = 7'(idx + 1);
					if (idx + 1 >= int'(dec_length)) begin
						close_frame();
					end
				end
			end
			default: begin
				dec_phase = PH_HUNT;
				if (b == set_head) begin
					dec_crc         = CRC_INIT;
					dec_bcc         = 8'h00;
					dec_esc_pending = 1'b0;
					dec_count       = '0;
					absorb_check(b);
					dec_phase = PH_HEAD2;
				end
			end
		endcase
	endfunction

	function automatic void store_setting(input logic [1:0] addr, input logic [7:0] val);
		case (addr)
			REG_HEAD:    set_head   = val;
			REG_ESCAPE:  set_escape = val;
			REG_MIN_LEN: set_min    = val[6:0];
			REG_MAX_LEN: set_max    = val[6:0];
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	// offer one word on s_*, return on the edge that takes it
	task automatic send_byte(input logic [7:0] b);
		while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sent_bytes++;
		decode_byte(b);
	endtask

	// sender holds off until the last expected word is out
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	// drive the decoder back to hunting with bytes that close whatever is open
	task automatic flush_to_hunt();
		logic [7:0] filler;
		while (dec_phase != PH_HUNT) begin
			if (dec_phase == PH_LENGTH) begin
				filler = 8'h00;     // below any check size, always a format error
			end else begin
				filler = 8'($urandom);
				while (filler == set_head || filler == set_escape) begin
					filler++;
				end
			end
			send_byte(filler);
		end
	endtask

	// registers change only with the decoder hunting and nothing in flight
	task automatic apply_settings(input logic [7:0] head, input logic [7:0] esc,
			input logic [7:0] min_w, input logic [7:0] max_w);
		logic [7:0] vals  [4];
		logic [1:0] addrs [4];
		flush_to_hunt();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		vals  = '{head, esc, min_w, max_w};
		addrs = '{REG_HEAD, REG_ESCAPE, REG_MIN_LEN, REG_MAX_LEN};
		for (int r = 0; r < 4; r++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= addrs[r];
			cfg_wdata <= vals[r];
			@(posedge clk);
			store_setting(addrs[r], vals[r]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_raw(input int n);
		for (int k = 0; k < n; k++) begin
			send_byte(frame_raw[k]);
		end
	endtask

	function automatic void push_stuffed(input logic [7:0] v);
		frame_raw.push_back(v);
		if (v == set_head) begin
			frame_raw.push_back(set_escape);
		end
	endfunction

	// build a frame around frame_payload and send it; len_byte >= 0 sends only
	// the header with that length value
	task automatic send_frame(input bit xor_mode, input frame_fault_t fault = FRAME_OK,
			input int len_byte = -1);
		logic [7:0]  ctl;
		logic [7:0]  bcc;
		logic [15:0] crc;
		logic [15:0] chk;
		int          n_chk;
		int          bad_at;
		int          cut;
		n_chk  = xor_mode ? 1 : 2;
		ctl    = 8'($urandom);
		ctl[6] = xor_mode;
		frame_raw = {};
		frame_raw.push_back(set_head);
		frame_raw.push_back(set_head);
		frame_raw.push_back(ctl);
		if (len_byte >= 0) begin
			frame_raw.push_back(8'(len_byte));
			send_raw(frame_raw.size());
			return;
		end
		frame_raw.push_back(8'(frame_payload.size() + n_chk));
		bad_at = (fault == FRAME_BAD_ESCAPE) ? $urandom_range(frame_payload.size()) : -1;
		for (int k = 0; k <= frame_payload.size(); k++) begin
			if (k == bad_at) begin
				// head byte followed by anything but the escape byte
				frame_raw.push_back(set_head);
				frame_raw.push_back(set_escape ^ 8'($urandom_range(255, 1)));
				send_raw(frame_raw.size());
				return;
			end
			if (k < frame_payload.size()) begin
				push_stuffed(frame_payload[k]);
			end
		end
		crc = CRC_INIT;
		bcc = 8'h00;
		foreach (frame_raw[i]) begin
			crc = x25_crc_update(crc, frame_raw[i]);
			bcc = bcc ^ frame_raw[i];
		end
		chk = xor_mode ? {8'h00, bcc} : ~crc;
		if (fault == FRAME_BAD_CHECK) begin
			chk[$urandom_range(n_chk * 8 - 1)] ^= 1'b1;
		end
		if (!xor_mode) begin
			push_stuffed(chk[15:8]);
		end
		push_stuffed(chk[7:0]);
		cut = (fault == FRAME_TRUNCATED) ? $urandom_range(frame_raw.size() - 1, 1)
		                                 : frame_raw.size();
		send_raw(cut);
	endtask

	// payload bytes lean toward the head, escape and extreme values
	function automatic logic [7:0] pick_payload_byte();
		int roll;
		roll = $urandom_range(7);
		case (roll)
			0, 1: return set_head;
			2:    return set_escape;
			3:    return 8'h00;
			4:    return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void fill_random_payload(input int n);
		frame_payload = {};
		repeat (n) frame_payload.push_back(pick_payload_byte());
	endfunction

	// mostly short payloads, now and then the longest the bounds allow
	function automatic int pick_payload_len(input bit xor_mode);
		int limit;
		int roll;
		limit = ((set_max > DEF_MAX_FRAME_LEN) ? DEF_MAX_FRAME_LEN : int'(set_max))
		        - (xor_mode ? 1 : 2);
		if (limit < 0) begin
			limit = 0;
		end
		roll = $urandom_range(99);
		if (roll < 80) begin
			return $urandom_range((limit < 8) ? limit : 8);
		end else if (roll < 95) begin
			return $urandom_range((limit < 24) ? limit : 24);
		end
		return limit;
	endfunction

	// ---------------------------------------------------------------- tests

	// stray bytes while hunting and a second byte that is not a head
	task automatic test_hunt_noise();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(set_escape);
		send_byte(set_head);
		send_byte(8'h12);
		send_byte(set_head);
		send_byte(8'h00);
	endtask

	task automatic test_good_frames();
		frame_payload = '{set_head, 8'h00, 8'hFF};
		send_frame(MODE_CRC);
		frame_payload = '{8'h01, set_head, 8'h80};
		send_frame(MODE_XOR);
		frame_payload = {};
		send_frame(MODE_CRC);               // valid empty frame
		frame_payload = '{set_escape};
		send_frame(MODE_XOR);
	endtask

	task automatic test_bad_frames();
		frame_payload = '{8'h11, 8'h22};
		send_frame(MODE_CRC, FRAME_BAD_CHECK);
		frame_payload = '{8'h33};
		send_frame(MODE_XOR, FRAME_BAD_CHECK);
		frame_payload = '{8'h44, 8'h45, 8'h46};
		send_frame(MODE_CRC, FRAME_BAD_ESCAPE);
		send_frame(MODE_CRC, FRAME_OK, 0);
		send_frame(MODE_CRC, FRAME_OK, 65);
		send_frame(MODE_XOR, FRAME_OK, 200);
		send_frame(MODE_XOR, FRAME_OK, 1);  // under the default minimum
	endtask

	task automatic test_config_extremes();
		// low head, high escape, widest bounds
		apply_settings(8'h00, 8'hFF, 8'd1, 8'd64);
		frame_payload = {};
		send_frame(MODE_XOR);               // length 1, empty
		send_frame(MODE_CRC, FRAME_OK, 1);  // shorter than the CRC
		frame_payload = '{8'h00, 8'hFF, 8'h00};
		send_frame(MODE_CRC);
		send_frame(MODE_XOR, FRAME_BAD_ESCAPE);
		// bit 7 of the length writes is masked; max reads back as 127
		apply_settings(8'hFF, 8'h00, 8'hC0, 8'hFF);
		fill_random_payload(62);
		send_frame(MODE_CRC);
		send_frame(MODE_CRC, FRAME_OK, 65);
		send_frame(MODE_XOR, FRAME_OK, 127);
		send_frame(MODE_CRC, FRAME_OK, 63);
		// head and escape equal
		apply_settings(8'h7E, 8'h7E, 8'd1, 8'd20);
		frame_payload = '{8'h7E, 8'h7E, 8'h01};
		send_frame(MODE_CRC);
		send_frame(MODE_XOR, FRAME_BAD_ESCAPE);
		fill_random_payload(19);
		send_frame(MODE_XOR);
		send_frame(MODE_CRC, FRAME_OK, 21);
		// min above max rejects every length
		apply_settings(8'hAA, 8'h55, 8'd40, 8'd10);
		frame_payload = '{8'h01, 8'h02};
		send_frame(MODE_CRC);
		send_frame(MODE_XOR, FRAME_OK, 40);
	endtask

	task automatic test_back_to_back();
		apply_settings(RST_HEAD, RST_ESCAPE, {1'b0, RST_MIN_LEN}, {1'b0, RST_MAX_LEN});
		steady_mode = 1'b1;
		for (int f = 0; f < 6; f++) begin
			fill_random_payload($urandom_range(6));
			send_frame(f[0]);
		end
		steady_mode = 1'b0;
	endtask

	task automatic test_random_traffic();
		int roll;
		int start;
		int frames;
		bit xor_mode;
		frames = 0;
		for (int p = 0; p < 4; p++) begin
			apply_settings(8'($urandom), 8'($urandom),
			               8'($urandom_range(4, 1)) | (8'($urandom_range(1)) << 7),
			               8'($urandom_range(64, 16)) | (8'($urandom_range(1)) << 7));
			start = sent_bytes;
			while (sent_bytes - start < RANDOM_BYTES) begin
				roll     = $urandom_range(99);
				xor_mode = 1'($urandom_range(1));
				if (roll < 12) begin
					// line noise, heavy on head bytes to hit the second-head check
					repeat ($urandom_range(6, 1)) begin
						send_byte(($urandom_range(2) == 0) ? set_head : 8'($urandom));
					end
				end else begin
					fill_random_payload(pick_payload_len(xor_mode));
					if (roll < 20) begin
						send_frame(xor_mode, FRAME_BAD_ESCAPE);
					end else if (roll < 27) begin
						send_frame(xor_mode, FRAME_TRUNCATED);
					end else if (roll < 33) begin
						send_frame(xor_mode, FRAME_OK, $urandom_range(255));
					end else if (roll < 45) begin
						send_frame(xor_mode, FRAME_BAD_CHECK);
					end else begin
						send_frame(xor_mode, FRAME_OK);
					end
				end
				frames++;
				if (frames == 5 || $urandom_range(15) == 0) begin
					hold_until_drained();
				end
			end
		end
	endtask

	// ---------------------------------------------------------------- checking

	// every word taken on m_* against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			mon_got.data   = m_tdata;
			mon_got.last   = m_tlast;
			mon_got.status = m_tuser;
			if (expected_words.size() == 0) begin
				error_count++;
				if (error_count <= 10) begin
					$display("unexpected word: data %02h last %0b status %0d",
					         mon_got.data, mon_got.last, mon_got.status);
				end
			end else begin
				mon_want = expected_words.pop_front();
				if (mon_got.data !== mon_want.data || mon_got.last !== mon_want.last ||
						mon_got.status !== mon_want.status) begin
					error_count++;
					if (error_count <= 10) begin
						$display({"mismatch: expected data %02h last %0b status %0d,",
						          " got data %02h last %0b status %0d"},
						         mon_want.data, mon_want.last, mon_want.status,
						         mon_got.data, mon_got.last, mon_got.status);
					end
				end
			end
		end
	end

	// receiver: ready drops at random, IDLE_PCT percent of the time, never in steady mode
	always @(posedge clk) begin
		m_tready <= steady_mode || ($urandom_range(99) >= IDLE_PCT);
	end

	initial begin
		#5000000;
		$display("FAIL stuffed_frame_decoder_crc_bcc");
		$finish;
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = 8'h00;
		m_tready    = 1'b0;
		cfg_we      = 1'b0;
		cfg_addr    = REG_HEAD;
		cfg_wdata   = 8'h00;
		error_count = 0;
		sent_bytes  = 0;
		steady_mode = 1'b0;
		set_head        = RST_HEAD;
		set_escape      = RST_ESCAPE;
		set_min         = RST_MIN_LEN;
		set_max         = RST_MAX_LEN;
		dec_phase       = PH_HUNT;
		dec_esc_pending = 1'b0;
		dec_count       = '0;
		dec_crc_mode    = 1'b0;
		dec_length      = '0;
		dec_crc         = CRC_INIT;
		dec_bcc         = 8'h00;
		dec_check_hist  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_hunt_noise();
		test_good_frames();
		test_bad_frames();
		test_config_extremes();
		test_back_to_back();
		test_random_traffic();

		flush_to_hunt();
		hold_until_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("PASS stuffed_frame_decoder_crc_bcc");
		end else begin
			$display("FAIL stuffed_frame_decoder_crc_bcc");
		end
		$finish;
	end

endmodule
